[sv/dsu_pkg.sv]
`default_nettype none

package dsu_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int IDX_W        = $clog2(MAX_ELEMENTS);
    localparam int CNT_W        = IDX_W + 1;
    localparam int CMD_W        = 2;
    localparam int S_TDATA_W    = 24;
    localparam int M_TDATA_W    = 24;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [CMD_W-1:0] op_t;

    localparam op_t CMD_UNITE     = 2'd0;
    localparam op_t CMD_CONNECTED = 2'd1;
    localparam op_t CMD_SIZE      = 2'd2;

    // read address select
    localparam logic [1:0] RD_A      = 2'd0;
    localparam logic [1:0] RD_B      = 2'd1;
    localparam logic [1:0] RD_PARENT = 2'd2;

    // write select
    localparam logic [1:0] WR_CLEAR    = 2'd0;
    localparam logic [1:0] WR_COMPRESS = 2'd1;
    localparam logic [1:0] WR_WINNER   = 2'd2;
    localparam logic [1:0] WR_LOSER    = 2'd3;

    // forest entry: a root keeps its group size, any other node its parent
    typedef struct packed {
        logic is_root;
        cnt_t val;
    } node_t;

    typedef struct packed {
        logic       load_item;
        logic       clr_start;
        logic       clr_step;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       phase;
        logic       latch_root;
        logic       wr_en;
        logic [1:0] wr_sel;
        logic       res_fault;
        logic       res_find;
        logic       count_dec;
        logic       load_out;
    } dsu_cmd_t;

    typedef struct packed {
        logic node_root;
        logic clr_last;
        logic item_fault;
        logic cmd_size;
        logic merge_needed;
        logic out_free;
    } dsu_stat_t;

endpackage

`default_nettype wire

[sv/dsu_datapath.sv]
`default_nettype none

module dsu_datapath import dsu_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire dsu_cmd_t  ctl,
    output dsu_stat_t      stat,
    input  wire op_t       in_cmd,
    input  wire idx_t      in_first,
    input  wire idx_t      in_second,
    input  wire logic      cfg_fire,
    input  wire cnt_t      cfg_value,
    input  wire logic      out_ready,
    output logic           out_valid,
    output logic           out_ok,
    output cnt_t           out_size,
    output cnt_t           out_count,
    output logic           out_err
);

    node_t mem [MAX_ELEMENTS];
    node_t rdata_reg;

    cnt_t  num_elem_reg, num_elem_next;
    cnt_t  count_reg, count_next;
    idx_t  clr_cnt_reg, clr_cnt_next;
    logic  valid_reg, valid_next;

    op_t   cmd_reg;
    idx_t  a_reg, b_reg, cur_reg;
    idx_t  root_a_reg, root_b_reg;
    cnt_t  size_a_reg, size_b_reg;
    logic  res_ok_reg, res_err_reg;
    cnt_t  res_size_reg;
    logic  ok_out_reg, err_out_reg;
    cnt_t  size_out_reg, count_out_reg;

    idx_t  rd_addr, wr_addr, phase_root, winner, loser;
    node_t wr_data;
    cnt_t  sum_size, cfg_clamped;
    logic  a_ge, b_ge, range_err, cmd_known, roots_differ;

    assign a_ge         = {1'b0, a_reg} >= num_elem_reg;
    assign b_ge         = {1'b0, b_reg} >= num_elem_reg;
    assign cmd_known    = (cmd_reg == CMD_UNITE) || (cmd_reg == CMD_CONNECTED)
                          || (cmd_reg == CMD_SIZE);
    assign range_err    = (cmd_reg == CMD_SIZE) ? a_ge :
                          ((cmd_reg == CMD_UNITE) || (cmd_reg == CMD_CONNECTED)) ? (a_ge || b_ge)
                          : 1'b0;
    assign roots_differ = root_a_reg != root_b_reg;
    assign sum_size     = cnt_t'(size_a_reg + size_b_reg);
    // tie keeps the first root on top
    assign winner       = (size_a_reg < size_b_reg) ? root_b_reg : root_a_reg;
    assign loser        = (size_a_reg < size_b_reg) ? root_a_reg : root_b_reg;
    assign phase_root   = ctl.phase ? root_b_reg : root_a_reg;

    always_comb begin
        if (cfg_value == '0) begin
            cfg_clamped = cnt_t'(1);
        end else if (cfg_value > cnt_t'(MAX_ELEMENTS)) begin
            cfg_clamped = cnt_t'(MAX_ELEMENTS);
        end else begin
            cfg_clamped = cfg_value;
        end
    end

    always_comb begin
        case (ctl.rd_sel)
            RD_A:      rd_addr = a_reg;
            RD_B:      rd_addr = b_reg;
            RD_PARENT: rd_addr = rdata_reg.val[IDX_W-1:0];
            default:   rd_addr = a_reg;
        endcase
    end

    always_comb begin
        case (ctl.wr_sel)
            WR_CLEAR: begin
                wr_addr = clr_cnt_reg;
                wr_data = '{is_root: 1'b1, val: cnt_t'(1)};
            end
            WR_COMPRESS: begin
                wr_addr = cur_reg;
                wr_data = '{is_root: 1'b0, val: {1'b0, phase_root}};
            end
            WR_WINNER: begin
                wr_addr = winner;
                wr_data = '{is_root: 1'b1, val: sum_size};
            end
            WR_LOSER: begin
                wr_addr = loser;
                wr_data = '{is_root: 1'b0, val: {1'b0, winner}};
            end
            default: begin
                wr_addr = clr_cnt_reg;
                wr_data = '{is_root: 1'b1, val: cnt_t'(1)};
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_comb begin
        num_elem_next = num_elem_reg;
        count_next    = count_reg;
        if (cfg_fire) begin
            num_elem_next = cfg_clamped;
            count_next    = cfg_clamped;
        end else if (ctl.count_dec && (count_reg != '0)) begin
            count_next = count_reg - cnt_t'(1);
        end

        clr_cnt_next = clr_cnt_reg;
        if (ctl.clr_start) begin
            clr_cnt_next = '0;
        end else if (ctl.clr_step) begin
            clr_cnt_next = clr_cnt_reg + idx_t'(1);
        end

        valid_next = valid_reg;
        if (ctl.load_out) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_elem_reg <= cnt_t'(MAX_ELEMENTS);
            count_reg    <= cnt_t'(MAX_ELEMENTS);
            clr_cnt_reg  <= '0;
            valid_reg    <= 1'b0;
        end else begin
            num_elem_reg <= num_elem_next;
            count_reg    <= count_next;
            clr_cnt_reg  <= clr_cnt_next;
            valid_reg    <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_item) begin
            cmd_reg <= in_cmd;
            a_reg   <= in_first;
            b_reg   <= in_second;
        end
        if (ctl.rd_en) begin
            cur_reg <= rd_addr;
        end
        if (ctl.latch_root) begin
            if (ctl.phase) begin
                root_b_reg <= cur_reg;
                size_b_reg <= rdata_reg.val;
            end else begin
                root_a_reg <= cur_reg;
                size_a_reg <= rdata_reg.val;
            end
        end
        if (ctl.res_fault) begin
            res_ok_reg   <= 1'b0;
            res_size_reg <= '0;
            res_err_reg  <= range_err;
        end else if (ctl.res_find) begin
            res_err_reg <= 1'b0;
            if (cmd_reg == CMD_UNITE) begin
                res_ok_reg   <= roots_differ;
                res_size_reg <= roots_differ ? sum_size : size_a_reg;
            end else begin
                res_ok_reg   <= (cmd_reg == CMD_CONNECTED) && !roots_differ;
                res_size_reg <= size_a_reg;
            end
        end
        if (ctl.load_out) begin
            ok_out_reg    <= res_ok_reg;
            size_out_reg  <= res_size_reg;
            count_out_reg <= count_reg;
            err_out_reg   <= res_err_reg;
        end
    end

    assign stat.node_root    = rdata_reg.is_root;
    assign stat.clr_last     = clr_cnt_reg == idx_t'(MAX_ELEMENTS - 1);
    assign stat.item_fault   = range_err || !cmd_known;
    assign stat.cmd_size     = cmd_reg == CMD_SIZE;
    assign stat.merge_needed = (cmd_reg == CMD_UNITE) && roots_differ;
    assign stat.out_free     = !valid_reg || out_ready;

    assign out_valid = valid_reg;
    assign out_ok    = ok_out_reg;
    assign out_size  = size_out_reg;
    assign out_count = count_out_reg;
    assign out_err   = err_out_reg;

endmodule

`default_nettype wire

[sv/dsu_ctrl.sv]
`default_nettype none

module dsu_ctrl import dsu_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire logic      cfg_fire,
    input  wire dsu_stat_t stat,
    output dsu_cmd_t       ctl
);

    localparam logic [2:0] ST_CLEAR    = 3'd0;
    localparam logic [2:0] ST_IDLE     = 3'd1;
    localparam logic [2:0] ST_DISPATCH = 3'd2;
    localparam logic [2:0] ST_WALK     = 3'd3;
    localparam logic [2:0] ST_COMP     = 3'd4;
    localparam logic [2:0] ST_DECIDE   = 3'd5;
    localparam logic [2:0] ST_MERGE    = 3'd6;
    localparam logic [2:0] ST_RESP     = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       phase_reg, phase_next;

    assign in_ready = (state_reg == ST_IDLE) && !cfg_fire;

    always_comb begin
        ctl        = '0;
        ctl.phase  = phase_reg;
        state_next = state_reg;
        phase_next = phase_reg;

        case (state_reg)
            ST_CLEAR: begin
                ctl.clr_step = 1'b1;
                ctl.wr_en    = 1'b1;
                ctl.wr_sel   = WR_CLEAR;
                if (stat.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_valid && in_ready) begin
                    ctl.load_item = 1'b1;
                    state_next    = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (stat.item_fault) begin
                    ctl.res_fault = 1'b1;
                    state_next    = ST_RESP;
                end else begin
                    ctl.rd_en  = 1'b1;
                    ctl.rd_sel = RD_A;
                    phase_next = 1'b0;
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                // follow parents up; at the root restart from the start node
                ctl.rd_en = 1'b1;
                if (stat.node_root) begin
                    ctl.latch_root = 1'b1;
                    ctl.rd_sel     = phase_reg ? RD_B : RD_A;
                    state_next     = ST_COMP;
                end else begin
                    ctl.rd_sel = RD_PARENT;
                end
            end
            ST_COMP: begin
                if (stat.node_root) begin
                    if (!phase_reg && !stat.cmd_size) begin
                        ctl.rd_en  = 1'b1;
                        ctl.rd_sel = RD_B;
                        phase_next = 1'b1;
                        state_next = ST_WALK;
                    end else begin
                        state_next = ST_DECIDE;
                    end
                end else begin
                    // point this node at the root, advance to its old parent
                    ctl.wr_en  = 1'b1;
                    ctl.wr_sel = WR_COMPRESS;
                    ctl.rd_en  = 1'b1;
                    ctl.rd_sel = RD_PARENT;
                end
            end
            ST_DECIDE: begin
                ctl.res_find = 1'b1;
                if (stat.merge_needed) begin
                    ctl.wr_en  = 1'b1;
                    ctl.wr_sel = WR_WINNER;
                    state_next = ST_MERGE;
                end else begin
                    state_next = ST_RESP;
                end
            end
            ST_MERGE: begin
                ctl.wr_en     = 1'b1;
                ctl.wr_sel    = WR_LOSER;
                ctl.count_dec = 1'b1;
                state_next    = ST_RESP;
            end
            ST_RESP: begin
                if (stat.out_free) begin
                    ctl.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase

        if (cfg_fire) begin
            ctl.clr_start = 1'b1;
            state_next    = ST_CLEAR;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            phase_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

endmodule

`default_nettype wire

[sv/disjoint_set_union_engine.sv]
// Channel   Dir  Handshake           Payload, lowest bit first
// s_        in   s_tvalid/s_tready   cmd[1:0] first_index[11:2] second_index[21:12]
// m_        out  m_tvalid/m_tready   ok_flag[0] group_size[11:1] group_count[22:12]
//                                    range_error[23]
// cfg_      in   cfg_valid/cfg_ready num_elements[10:0]
//
// One item at a time. A lookup walks the parent chain through the forest RAM, one
// node a cycle, then walks it again to repoint every node at the root. A unite that
// merges adds a state that writes the losing root; a size query walks one chain;
// a rejected item skips the walks and goes straight to the response.
// After reset and after every num_elements write a clearing pass rewrites all 1024
// words of the forest RAM; no word is taken on s_ meanwhile.
// A stalled result sits in the output register while the next word is taken.
`default_nettype none

module disjoint_set_union_engine import dsu_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // cmd, first_index, second_index
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,   // ok_flag, group_size, group_count,
                                                 // range_error
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CNT_W-1:0]     cfg_data   // num_elements
);

    dsu_cmd_t  ctl;
    dsu_stat_t stat;
    logic      cfg_fire;
    logic      out_ok, out_err;
    cnt_t      out_size, out_count;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid;

    dsu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .cfg_fire (cfg_fire),
        .stat     (stat),
        .ctl      (ctl)
    );

    dsu_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .stat      (stat),
        .in_cmd    (s_tdata[CMD_W-1:0]),
        .in_first  (s_tdata[CMD_W+IDX_W-1:CMD_W]),
        .in_second (s_tdata[CMD_W+2*IDX_W-1:CMD_W+IDX_W]),
        .cfg_fire  (cfg_fire),
        .cfg_value (cfg_data),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_ok    (out_ok),
        .out_size  (out_size),
        .out_count (out_count),
        .out_err   (out_err)
    );

    assign m_tdata = {out_err, out_count, out_size, out_ok};

endmodule

`default_nettype wire

[sv/dsu_checker.sv]
`default_nettype none

module dsu_checker import dsu_pkg::*; (
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic                 cfg_valid,
    input wire logic                 cfg_ready
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one item in flight: no word right after an accepted one
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word taken while busy");

    // a register write starts the clearing pass
    a_cfg_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready |=> !s_tready)
        else $error("word taken during clearing pass");

    // a flagged index reports no merge and no size
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[M_TDATA_W-1] |-> m_tdata[CNT_W:0] == '0)
        else $error("range error with nonzero result");

    a_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[CNT_W:1] <= cnt_t'(MAX_ELEMENTS))
                     && (m_tdata[2*CNT_W:CNT_W+1] <= cnt_t'(MAX_ELEMENTS)))
        else $error("size or count beyond element limit");

endmodule

bind disjoint_set_union_engine dsu_checker u_dsu_checker (.*);

`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 100ps

module testbench;
    import dsu_pkg::*;

    localparam op_t CMD_UNUSED = 2'd3;
    localparam int  SETTLE     = 64;     // longest item plus margin
    localparam int  IDLE_LIMIT = 8000;   // covers the clearing pass
    localparam int  PHASE_LEN  = 172;
    localparam int  CALM_TAIL  = 150;

    typedef enum logic [1:0] {K_WORD, K_CFG, K_DRAIN} step_kind_e;

    typedef struct {
        step_kind_e kind;
        op_t        cmd;
        idx_t       a;
        idx_t       b;
        cnt_t       value;
    } step_t;

    // same layout as m_tdata, highest bit first
    typedef struct packed {
        logic rerr;
        cnt_t gcount;
        cnt_t gsize;
        logic ok;
    } reply_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CNT_W-1:0]     cfg_data = '0;

    step_t  pending[$];
    reply_t replies_due[$];

    // mirror of the forest
    logic        node_root [MAX_ELEMENTS];
    int unsigned node_up   [MAX_ELEMENTS];
    int unsigned node_size [MAX_ELEMENTS];
    int unsigned group_total;
    int unsigned population;

    bit word_taken = 0;
    bit cfg_taken  = 0;
    int gap_left    = 0;
    int stall_left  = 0;
    int settle_left = SETTLE;
    int idle_cycles = 0;
    int fails       = 0;
    int checked     = 0;
    int merges_seen = 0;
    int rerr_seen   = 0;
    int cfg_writes  = 0;
    int largest     = 0;

    disjoint_set_union_engine DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    function automatic void make_singletons();
        for (int i = 0; i < MAX_ELEMENTS; i++) begin
            node_root[i] = 1'b1;
            node_up[i]   = i;
            node_size[i] = 1;
        end
        group_total = population;
    endfunction

    function automatic void set_population(cnt_t value);
        population = value;
        if (population == 0)
            population = 1;
        if (population > MAX_ELEMENTS)
            population = MAX_ELEMENTS;
        make_singletons();
    endfunction

    // find the leader and point the whole walked path at it
    function automatic int unsigned find_leader(int unsigned x);
        int unsigned r;
        int unsigned nxt;
        r = x;
        while (!node_root[r])
            r = node_up[r];
        while (x != r) begin
            nxt = node_up[x];
            node_up[x] = r;
            x = nxt;
        end
        return r;
    endfunction

    function automatic reply_t apply_command(op_t cmd, idx_t a, idx_t b);
        reply_t      rep;
        int unsigned ra;
        int unsigned rb;
        int unsigned t;
        rep = '0;
        if (cmd == CMD_UNITE || cmd == CMD_CONNECTED) begin
            if (a >= population || b >= population) begin
                rep.rerr = 1'b1;
            end else begin
                ra = find_leader(a);
                rb = find_leader(b);
                if (cmd == CMD_CONNECTED) begin
                    rep.ok = (ra == rb);
                end else if (ra != rb) begin
                    // smaller group hangs under the larger, tie keeps the first
                    if (node_size[ra] < node_size[rb]) begin
                        t  = ra;
                        ra = rb;
                        rb = t;
                    end
                    node_size[ra] += node_size[rb];
                    node_root[rb] = 1'b0;
                    node_up[rb]   = ra;
                    if (group_total > 0)
                        group_total--;
                    rep.ok = 1'b1;
                end
                rep.gsize = cnt_t'(node_size[find_leader(a)]);
            end
        end else if (cmd == CMD_SIZE) begin
            if (a >= population)
                rep.rerr = 1'b1;
            else
                rep.gsize = cnt_t'(node_size[find_leader(a)]);
        end
        rep.gcount = cnt_t'(group_total);
        return rep;
    endfunction

    function automatic void push_word(op_t cmd, int unsigned a, int unsigned b);
        step_t st;
        st.kind  = K_WORD;
        st.cmd   = cmd;
        st.a     = idx_t'(a);
        st.b     = idx_t'(b);
        st.value = '0;
        pending.push_back(st);
    endfunction

    function automatic void push_control(step_kind_e kind, cnt_t value);
        step_t st;
        st.kind  = kind;
        st.cmd   = CMD_UNITE;
        st.a     = '0;
        st.b     = '0;
        st.value = value;
        pending.push_back(st);
    endfunction

    function automatic int unsigned pick_index(int unsigned n, int unsigned hot_base,
                                               int unsigned hot_span);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (n < MAX_ELEMENTS && r < 8)
            return $urandom_range(n, MAX_ELEMENTS - 1);
        if (r < 55)
            return hot_base + $urandom_range(0, hot_span - 1);
        return $urandom_range(0, n - 1);
    endfunction

    function automatic op_t pick_cmd();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return CMD_UNITE;
        if (r < 70)
            return CMD_CONNECTED;
        if (r < 93)
            return CMD_SIZE;
        return CMD_UNUSED;
    endfunction

    // drive inputs on the falling edge
    always @(negedge aclk) begin : drive
        logic  nxt_s;
        logic  nxt_c;
        logic  nxt_r;
        logic  calm;
        step_t st;
        nxt_s = s_tvalid;
        nxt_c = cfg_valid;
        calm  = (pending.size() < CALM_TAIL);
        if (word_taken)
            nxt_s = 1'b0;
        if (cfg_taken)
            nxt_c = 1'b0;
        word_taken = 0;
        cfg_taken  = 0;
        if (aresetn && !nxt_s && !nxt_c) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending.size() > 0) begin
                st = pending[0];
                if (st.kind == K_WORD) begin
                    s_tdata <= {2'b00, st.b, st.a, st.cmd};
                    nxt_s = 1'b1;
                    void'(pending.pop_front());
                    if (!calm && $urandom_range(0, 3) == 0)
                        gap_left = $urandom_range(1, 5);
                end else if (replies_due.size() != 0) begin
                    // hold until every result is back, then let the block settle
                    settle_left = SETTLE;
                end else if (settle_left > 0) begin
                    settle_left--;
                end else begin
                    if (st.kind == K_CFG) begin
                        cfg_data <= st.value;
                        nxt_c = 1'b1;
                    end
                    void'(pending.pop_front());
                    settle_left = SETTLE;
                end
            end
        end
        if (stall_left > 0) begin
            nxt_r = 1'b0;
            stall_left--;
        end else begin
            nxt_r = 1'b1;
            if (!calm && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 5);
        end
        s_tvalid  <= nxt_s;
        cfg_valid <= nxt_c;
        m_tready  <= nxt_r;
    end

    // sample handshakes on the rising edge
    always @(posedge aclk) begin : observe
        reply_t got;
        reply_t want;
        logic   moved;
        moved = 1'b0;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                moved = 1'b1;
                got   = reply_t'(m_tdata);
                if (replies_due.size() == 0) begin
                    $error("result word with nothing expected: %h", m_tdata);
                    fails++;
                end else begin
                    want = replies_due.pop_front();
                    checked++;
                    if (got.ok !== want.ok) begin
                        $error("ok_flag: expected %0d, got %0d", want.ok, got.ok);
                        fails++;
                    end
                    if (got.gsize !== want.gsize) begin
                        $error("group_size: expected %0d, got %0d", want.gsize, got.gsize);
                        fails++;
                    end
                    if (got.gcount !== want.gcount) begin
                        $error("group_count: expected %0d, got %0d",
                               want.gcount, got.gcount);
                        fails++;
                    end
                    if (got.rerr !== want.rerr) begin
                        $error("range_error: expected %0d, got %0d", want.rerr, got.rerr);
                        fails++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                moved = 1'b1;
                want  = apply_command(op_t'(s_tdata[1:0]), idx_t'(s_tdata[11:2]),
                                      idx_t'(s_tdata[21:12]));
                if (want.ok && s_tdata[1:0] == CMD_UNITE)
                    merges_seen++;
                if (want.rerr)
                    rerr_seen++;
                if (want.gsize > largest)
                    largest = want.gsize;
                replies_due.push_back(want);
                word_taken = 1;
            end
            if (cfg_valid && cfg_ready) begin
                moved = 1'b1;
                set_population(cfg_data);
                cfg_writes++;
                cfg_taken = 1;
            end
            if (moved) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
                    $display("testbench NOT OK");
                    $finish;
                end
            end
        end
    end

    initial begin : stimulus
        cnt_t        phase_sizes [10];
        int unsigned n;
        int unsigned hot_span;
        int unsigned hot_base;
        op_t         cmd;

        population = MAX_ELEMENTS;
        make_singletons();

        phase_sizes = '{11'd2047, 11'd7, 11'd64, 11'd1000, 11'd2, 11'd300,
                        11'd1024, 11'd16, 11'd512, 11'd1023};

        // directed part at the reset size of 1024
        push_word(CMD_SIZE, 0, 0);
        push_word(CMD_SIZE, 1023, 1023);
        push_word(CMD_CONNECTED, 0, 1023);
        push_word(CMD_UNITE, 0, 1023);
        push_word(CMD_CONNECTED, 1023, 0);
        push_word(CMD_UNITE, 1023, 0);         // already one group
        push_word(CMD_UNITE, 512, 0);          // singleton joins the pair
        push_word(CMD_SIZE, 512, 0);
        push_word(CMD_UNUSED, 1023, 1023);
        push_word(CMD_CONNECTED, 5, 5);
        // zero is taken as one item
        push_control(K_CFG, 11'd0);
        push_word(CMD_UNITE, 0, 0);
        push_word(CMD_SIZE, 0, 0);
        push_word(CMD_CONNECTED, 0, 1);
        push_word(CMD_SIZE, 1023, 0);
        push_word(CMD_UNITE, 1023, 0);
        push_word(CMD_UNUSED, 1023, 1023);     // unused code, out-of-range indices
        // ties: the second root hangs under the first
        push_control(K_CFG, 11'd4);
        push_word(CMD_UNITE, 2, 3);
        push_word(CMD_UNITE, 1, 0);
        push_word(CMD_UNITE, 0, 3);
        push_word(CMD_SIZE, 3, 0);
        push_word(CMD_CONNECTED, 3, 0);
        push_word(CMD_SIZE, 4, 0);
        push_word(CMD_UNITE, 0, 4);

        // random phases, each after a fresh register write
        foreach (phase_sizes[p]) begin
            push_control(K_CFG, phase_sizes[p]);
            n = phase_sizes[p];
            if (n > MAX_ELEMENTS)
                n = MAX_ELEMENTS;
            hot_span = (n < 24) ? n : 24;
            hot_base = $urandom_range(0, n - hot_span);
            for (int i = 0; i < PHASE_LEN; i++) begin
                if (p == 3 && i == PHASE_LEN / 2)
                    push_control(K_DRAIN, '0);
                cmd = pick_cmd();
                push_word(cmd, pick_index(n, hot_base, hot_span),
                          pick_index(n, hot_base, hot_span));
            end
        end

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pending.size() != 0 || s_tvalid || cfg_valid || replies_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (replies_due.size() != 0) begin
            $error("%0d results never arrived", replies_due.size());
            fails++;
        end

        $display("checked %0d results over %0d register writes: %0d merges, %0d range errors",
                 checked, cfg_writes, merges_seen, rerr_seen);
        $display("largest group seen %0d items, %0d mismatches", largest, fails);
        if (fails == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

[files.f]
sv/dsu_pkg.sv
sv/dsu_datapath.sv
sv/dsu_ctrl.sv
sv/disjoint_set_union_engine.sv
sv/dsu_checker.sv
sim/testbench.sv
